// ===== src/interval_reservation_table_top_assert.svh =====
// Assertion helpers for the reservation table
`ifndef INTERVAL_RESERVATION_TABLE_TOP_ASSERT_SVH
`define INTERVAL_RESERVATION_TABLE_TOP_ASSERT_SVH

// Same-cycle implication
`define IRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/irt_pkg.sv =====
package irt_pkg;

  // Request codes
  typedef enum logic [2:0] {
    OP_ADD          = 3'd0,
    OP_REMOVE       = 3'd1,
    OP_REMOVE_GROUP = 3'd2,
    OP_CLEAR        = 3'd3,
    OP_UPDATE       = 3'd4
  } irt_op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } irt_state_e;

  // Request beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [15:0] patrol_id;
    logic        tag_present;
    logic [31:0] tag_time;
    logic [31:0] key_start;
    logic [31:0] key_end;
  } irt_req_t;

  // Response beat
  typedef struct packed {
    logic       ok;
    logic [4:0] entries_used;
  } irt_rsp_t;

  // One stored slot
  typedef struct packed {
    logic        tag_present;
    logic [31:0] tag_time;
    logic [15:0] patrol_id;
    logic [31:0] end_time;
    logic [31:0] start_time;
  } irt_entry_t;

endpackage

// ===== src/irt_req_if.sv =====
interface irt_req_if;
  import irt_pkg::*;

  logic     valid;
  logic     ready;
  irt_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/irt_rsp_if.sv =====
interface irt_rsp_if;
  import irt_pkg::*;

  logic     valid;
  logic     ready;
  irt_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/irt_ram.sv =====
module irt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/interval_reservation_table_top.sv =====
// Interval reservation table, one request at a time.
// Add, remove, group remove and update scan every slot through one compare set,
// then commit; clear and unknown codes skip the scan and go straight to commit.
// A new request is taken only after the previous one commits its response.
// The scan rate is set by the single read port of the slot RAM.
// Reset empties the table at once (valid bits in flops); slot data is not reset.
module interval_reservation_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  irt_req_if.sink     req_i,
  irt_rsp_if.source   rsp_o
);
  import irt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(irt_entry_t);

  // Closed-interval overlap, four tests
  function automatic logic overlaps(logic [31:0] es, logic [31:0] ee,
                                    logic [31:0] s, logic [31:0] e);
    logic hit;
    hit = (es <= s && s <= ee) || (s <= es && ee <= e) ||
          (es <= e && e <= ee) || (es <= s && e <= ee);
    return hit;
  endfunction

  irt_state_e           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        count_q, count_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic                 found_q, found_d;
  logic                 conflict_q, conflict_d;
  logic [AW-1:0]        match_q, match_d;
  irt_req_t             req_q;
  logic                 rsp_valid_q, rsp_valid_d;
  irt_rsp_t             rsp_q, rsp_d;

  logic                 req_fire;
  logic                 commit_go;
  logic [AW-1:0]        cmp_idx;
  logic                 cmp_en;
  irt_entry_t           rd_entry;
  logic [EW-1:0]        rd_data;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  irt_entry_t           ram_wentry;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign commit_go   = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_o.ready);
  assign cmp_idx     = AW'(cnt_q - CW'(1));
  assign cmp_en      = (state_q == ST_SCAN) && (cnt_q != '0);
  assign rd_entry    = irt_entry_t'(rd_data);

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Slot storage
  irt_ram #(
    .Width (EW),
    .Depth (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (EW'(ram_wentry)),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Sequencer: scan, then commit and respond
  always_comb begin
    logic v;
    logic key_hit;
    logic grp_hit;
    logic ovl;

    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    valid_d     = valid_q;
    found_d     = found_q;
    conflict_d  = conflict_q;
    match_d     = match_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = match_q;
    ram_wentry  = '0;

    v       = valid_q[cmp_idx];
    ovl     = overlaps(rd_entry.start_time, rd_entry.end_time,
                       req_q.start_time, req_q.end_time);
    key_hit = v && (rd_entry.start_time == req_q.key_start) &&
              (rd_entry.end_time == req_q.key_end);
    grp_hit = v && (rd_entry.tag_present == req_q.tag_present) &&
              (!req_q.tag_present || rd_entry.tag_time == req_q.tag_time);

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          cnt_d      = '0;
          found_d    = 1'b0;
          conflict_d = 1'b0;
          if (req_i.data.req_type == OP_ADD || req_i.data.req_type == OP_REMOVE ||
              req_i.data.req_type == OP_REMOVE_GROUP ||
              req_i.data.req_type == OP_UPDATE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cmp_en) begin
          unique case (req_q.req_type)
            OP_ADD: begin
              if (v && ovl) begin
                conflict_d = 1'b1;
              end
              if (!v && !found_q) begin
                found_d = 1'b1;
                match_d = cmp_idx;
              end
            end
            OP_UPDATE: begin
              if (key_hit && !found_q) begin
                found_d = 1'b1;
                match_d = cmp_idx;
              end else if (v && ovl) begin
                conflict_d = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (key_hit && !found_q) begin
                found_d = 1'b1;
                match_d = cmp_idx;
              end
            end
            OP_REMOVE_GROUP: begin
              if (grp_hit) begin
                valid_d[cmp_idx] = 1'b0;
                count_d          = count_q - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        if (cnt_q == CW'(TABLE_DEPTH)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          rsp_d.ok = 1'b0;
          unique case (req_q.req_type)
            OP_ADD: begin
              if (found_q && !conflict_q) begin
                rsp_d.ok               = 1'b1;
                ram_we                 = 1'b1;
                ram_wentry.start_time  = req_q.start_time;
                ram_wentry.end_time    = req_q.end_time;
                ram_wentry.patrol_id   = req_q.patrol_id;
                ram_wentry.tag_present = req_q.tag_present;
                ram_wentry.tag_time    = req_q.tag_present ? req_q.tag_time : '0;
                valid_d[match_q]       = 1'b1;
                count_d                = count_q + CW'(1);
              end
            end
            OP_UPDATE: begin
              if (found_q && !conflict_q) begin
                rsp_d.ok              = 1'b1;
                ram_we                = 1'b1;
                ram_wentry.start_time = req_q.start_time;
                ram_wentry.end_time   = req_q.end_time;
                ram_wentry.patrol_id  = req_q.patrol_id;
              end
            end
            OP_REMOVE: begin
              rsp_d.ok = 1'b1;
              if (found_q) begin
                valid_d[match_q] = 1'b0;
                count_d          = count_q - CW'(1);
              end
            end
            OP_REMOVE_GROUP: begin
              rsp_d.ok = 1'b1;
            end
            OP_CLEAR: begin
              rsp_d.ok = 1'b1;
              valid_d  = '0;
              count_d  = '0;
            end
            default: begin
            end
          endcase
          rsp_d.entries_used = 5'(count_d);
          rsp_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      valid_q     <= '0;
      found_q     <= 1'b0;
      conflict_q  <= 1'b0;
      match_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      found_q     <= found_d;
      conflict_q  <= conflict_d;
      match_q     <= match_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i.data;
    end
    rsp_q <= rsp_d;
  end

`include "interval_reservation_table_top_assert.svh"

  `IRT_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CW'(TABLE_DEPTH), "used count above depth")
  `IRT_ASSERT_IMPL(a_count_sync, state_q == ST_IDLE, count_q == CW'($countones(valid_q)), "used count out of step with valid bits")
  `IRT_ASSERT_NEXT(a_fail_no_change, commit_go && !rsp_d.ok, $stable(valid_q) && $stable(count_q), "failed request changed the table")
  `IRT_ASSERT_NEXT(a_add_grows, commit_go && rsp_d.ok && req_q.req_type == OP_ADD, count_q == $past(count_q) + CW'(1), "add did not grow the table")

endmodule

// ===== dv/interval_reservation_table_top_tb.sv =====
module interval_reservation_table_top_tb;
  import irt_pkg::*;

  localparam int          DEPTH          = 16;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          SETTLE_CYCLES  = 40;
  // request codes the block does not use
  localparam logic [2:0]  REQ_SPARE_LO   = 3'd5;
  localparam logic [2:0]  REQ_SPARE_HI   = 3'd7;
  localparam logic [31:0] TIME_MAX       = 32'hFFFF_FFFF;

  logic clk;
  logic rst_n;

  irt_req_if req_if ();
  irt_rsp_if rsp_if ();

  interval_reservation_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the reservation table
  bit          book_live  [DEPTH];
  logic [31:0] book_start [DEPTH];
  logic [31:0] book_end   [DEPTH];
  logic [15:0] book_patrol[DEPTH];
  bit          book_tagged[DEPTH];
  logic [31:0] book_tag   [DEPTH];

  irt_rsp_t    booking_status_q[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Closed-interval clash, four tests as the block defines them
  function automatic bit intervals_clash(logic [31:0] bs, logic [31:0] be,
                                         logic [31:0] s, logic [31:0] e);
    return (bs <= s && s <= be) || (s <= bs && be <= e) ||
           (bs <= e && e <= be) || (bs <= s && e <= be);
  endfunction

  // skip < 0 means no slot is left out
  function automatic bit span_free(logic [31:0] s, logic [31:0] e, int skip);
    for (int i = 0; i < DEPTH; i++) begin
      if (i != skip && book_live[i] && intervals_clash(book_start[i], book_end[i], s, e))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int find_booking(logic [31:0] ks, logic [31:0] ke);
    for (int i = 0; i < DEPTH; i++) begin
      if (book_live[i] && book_start[i] == ks && book_end[i] == ke) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the status it yields
  function automatic irt_rsp_t apply_booking_request(irt_req_t r);
    irt_rsp_t st;
    int       slot;
    int       used;
    st.ok = 1'b0;
    case (r.req_type)
      OP_ADD: begin
        if (span_free(r.start_time, r.end_time, -1)) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!book_live[i]) begin
              book_live[i]   = 1'b1;
              book_start[i]  = r.start_time;
              book_end[i]    = r.end_time;
              book_patrol[i] = r.patrol_id;
              book_tagged[i] = r.tag_present;
              book_tag[i]    = r.tag_present ? r.tag_time : '0;
              st.ok = 1'b1;
              break;
            end
          end
        end
      end
      OP_REMOVE: begin
        slot = find_booking(r.key_start, r.key_end);
        if (slot >= 0) book_live[slot] = 1'b0;
        st.ok = 1'b1;
      end
      OP_REMOVE_GROUP: begin
        // absent tag matches every untagged entry
        for (int i = 0; i < DEPTH; i++) begin
          if (book_live[i] && book_tagged[i] == r.tag_present &&
              (!r.tag_present || book_tag[i] == r.tag_time))
            book_live[i] = 1'b0;
        end
        st.ok = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) book_live[i] = 1'b0;
        st.ok = 1'b1;
      end
      OP_UPDATE: begin
        slot = find_booking(r.key_start, r.key_end);
        if (slot >= 0 && span_free(r.start_time, r.end_time, slot)) begin
          book_start[slot]  = r.start_time;
          book_end[slot]    = r.end_time;
          book_patrol[slot] = r.patrol_id;
          book_tagged[slot] = 1'b0;
          book_tag[slot]    = '0;
          st.ok = 1'b1;
        end
      end
      default: ;
    endcase
    used = 0;
    for (int i = 0; i < DEPTH; i++) used += book_live[i];
    st.entries_used = used[4:0];
    return st;
  endfunction

  function automatic irt_req_t mk_req(logic [2:0] op, logic [31:0] s, logic [31:0] e,
                                      logic [15:0] pat, logic tp, logic [31:0] tag,
                                      logic [31:0] ks, logic [31:0] ke);
    irt_req_t r;
    r.req_type    = op;
    r.start_time  = s;
    r.end_time    = e;
    r.patrol_id   = pat;
    r.tag_present = tp;
    r.tag_time    = tag;
    r.key_start   = ks;
    r.key_end     = ke;
    return r;
  endfunction

  // Send one request beat; called at a rising edge, returns at the accepting edge
  task automatic send_request(irt_req_t r);
    int unsigned gap;
    gap = 0;
    while (gap < 30 && chance(send_idle_pct)) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    booking_status_q.push_back(apply_booking_request(r));
  endtask

  // Stop sending and wait for every outstanding status beat
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (booking_status_q.size() != 0);
  endtask

  // Status checker and receiver stall
  always @(posedge clk) begin
    irt_rsp_t exp_st;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (booking_status_q.size() == 0) begin
        $error("unexpected status beat: ok=%0b entries_used=%0d",
               rsp_if.data.ok, rsp_if.data.entries_used);
        mismatches++;
      end else begin
        exp_st = booking_status_q.pop_front();
        if (rsp_if.data.ok !== exp_st.ok) begin
          $error("ok: expected %0b, actual %0b", exp_st.ok, rsp_if.data.ok);
          mismatches++;
        end
        if (rsp_if.data.entries_used !== exp_st.entries_used) begin
          $error("entries_used: expected %0d, actual %0d",
                 exp_st.entries_used, rsp_if.data.entries_used);
          mismatches++;
        end
      end
    end
    rsp_if.ready <= !chance(recv_stall_pct);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Boundary values, each clash test, tags, update and unused codes
  task automatic test_directed_ops();
    send_request(mk_req(OP_REMOVE, 0, 0, 0, 0, 0, 100, 200));
    send_request(mk_req(OP_UPDATE, 10, 20, 0, 0, 0, 100, 200));
    send_request(mk_req(REQ_SPARE_LO, 100, 200, 16'hFFFF, 1, TIME_MAX, 0, 0));
    send_request(mk_req(REQ_SPARE_HI, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(OP_ADD, 100, 200, 16'hFFFF, 1, TIME_MAX, 0, 0));
    // start inside, covering, end inside, fully inside
    send_request(mk_req(OP_ADD, 150, 300, 1, 0, 0, 0, 0));
    send_request(mk_req(OP_ADD, 50, 250, 2, 0, 0, 0, 0));
    send_request(mk_req(OP_ADD, 50, 150, 3, 0, 0, 0, 0));
    send_request(mk_req(OP_ADD, 120, 180, 4, 0, 0, 0, 0));
    // adjacent, tag ignored when absent
    send_request(mk_req(OP_ADD, 201, 300, 0, 0, TIME_MAX, 0, 0));
    send_request(mk_req(OP_ADD, 0, 0, 16'h5555, 1, 0, 0, 0));
    send_request(mk_req(OP_ADD, TIME_MAX, TIME_MAX, 16'hAAAA, 0, 0, 0, 0));
    // inverted interval taken as given
    send_request(mk_req(OP_ADD, 500, 400, 16'h0F0F, 1, TIME_MAX, 0, 0));
    send_request(mk_req(OP_UPDATE, 150, 350, 7, 0, 0, 201, 300));
    // clash only with itself, tag dropped
    send_request(mk_req(OP_UPDATE, 90, 200, 16'h1234, 1, TIME_MAX, 100, 200));
    send_request(mk_req(OP_REMOVE_GROUP, 0, 0, 0, 1, TIME_MAX, 0, 0));
    send_request(mk_req(OP_REMOVE_GROUP, 0, 0, 0, 0, 32'h1234_5678, 0, 0));
    send_request(mk_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(OP_ADD, 0, TIME_MAX, 16'hA5A5, 0, 0, 0, 0));
    send_request(mk_req(OP_ADD, 7, 9, 1, 0, 0, 0, 0));
    send_request(mk_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 5));
    send_request(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    drain_responses();
  endtask

  // Fill every slot, add into a full table, then reuse freed slots
  task automatic test_full_table();
    for (int i = 0; i < DEPTH; i++)
      send_request(mk_req(OP_ADD, i * 10, i * 10 + 5, 16'(i), i[0], 32'hC0DE, 0, 0));
    send_request(mk_req(OP_ADD, 1000, 1005, 99, 0, 0, 0, 0));
    send_request(mk_req(OP_UPDATE, 1000, 1005, 98, 0, 0, 50, 55));
    send_request(mk_req(OP_REMOVE_GROUP, 0, 0, 0, 1, 32'hC0DE, 0, 0));
    send_request(mk_req(OP_ADD, 2000, 2001, 97, 1, 32'hC0DE, 0, 0));
    send_request(mk_req(OP_REMOVE, 0, 0, 0, 0, 0, 2000, 2001));
    send_request(mk_req(OP_REMOVE, 0, 0, 0, 0, 0, 1000, 1005));
    send_request(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    drain_responses();
  endtask

  function automatic logic [31:0] random_time();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(3000);
    if (roll < 95) return $urandom;
    return chance(50) ? '0 : TIME_MAX;
  endfunction

  function automatic logic [31:0] random_tag();
    case ($urandom_range(4))
      0: return '0;
      1: return 32'd1;
      2: return TIME_MAX;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic aimed at live bookings, some noise
  function automatic irt_req_t random_request();
    irt_req_t    r;
    int          live[$];
    int          pick;
    int unsigned roll;
    r.start_time  = random_time();
    r.end_time    = chance(5) ? r.start_time - $urandom_range(40)
                              : r.start_time + $urandom_range(60);
    if (chance(5)) r.end_time = $urandom;
    r.patrol_id   = 16'($urandom);
    r.tag_present = 1'($urandom_range(1));
    r.tag_time    = random_tag();
    for (int i = 0; i < DEPTH; i++) if (book_live[i]) live.push_back(i);
    if (live.size() != 0 && chance(80)) begin
      pick        = live[$urandom_range(live.size() - 1)];
      r.key_start = book_start[pick];
      r.key_end   = book_end[pick];
      if (book_tagged[pick] && chance(50)) begin
        r.tag_present = 1'b1;
        r.tag_time    = book_tag[pick];
      end
      // small move of an existing booking
      if (chance(40)) begin
        r.start_time = book_start[pick] + $urandom_range(6) - 3;
        r.end_time   = book_end[pick] + $urandom_range(6) - 3;
      end
    end else begin
      r.key_start = random_time();
      r.key_end   = chance(50) ? r.key_start + $urandom_range(60) : random_time();
    end
    roll = $urandom_range(99);
    if (roll < 45)      r.req_type = OP_ADD;
    else if (roll < 60) r.req_type = OP_REMOVE;
    else if (roll < 68) r.req_type = OP_REMOVE_GROUP;
    else if (roll < 70) r.req_type = OP_CLEAR;
    else if (roll < 97) r.req_type = OP_UPDATE;
    else                r.req_type = 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
    return r;
  endfunction

  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                     int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < n_items; n++) send_request(random_request());
    drain_responses();
  endtask

  // Sequence of tests
  initial begin
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_full_table();
    test_random_traffic(275, 0, 0);
    test_random_traffic(275, 70, 0);
    test_random_traffic(275, 0, 70);
    test_random_traffic(275, 34, 34);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
